@@ rtl/twdt_pkg.sv @@
// Package for the two-stage watchdog timer: request/result structs, command
// codes, register offsets and unlock constants.
// No dependencies.
package twdt_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  address;
        logic [2:0]  access_bytes;
        logic [31:0] write_data;
    } twdt_req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        stage_one_alert;
        logic [1:0]  alert_kind;
        logic        reboot_request;
        logic        counting;
    } twdt_rsp_t;

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_CFG_WR = 3'd1;
    localparam logic [2:0] CMD_CFG_RD = 3'd2;
    localparam logic [2:0] CMD_MEM_WR = 3'd3;
    localparam logic [2:0] CMD_MEM_RD = 3'd4;

    // Access sizes
    localparam logic [2:0] LEN_BYTE  = 3'd1;
    localparam logic [2:0] LEN_HALF  = 3'd2;
    localparam logic [2:0] LEN_WORD  = 3'd4;

    // Config space offsets
    localparam logic [7:0] ADDR_CFG_CTRL = 8'h60;
    localparam logic [7:0] ADDR_CFG_LOCK = 8'h68;

    // Memory window offsets
    localparam logic [7:0] ADDR_MEM_PRE1   = 8'h00;
    localparam logic [7:0] ADDR_MEM_PRE2   = 8'h04;
    localparam logic [7:0] ADDR_MEM_RELOAD = 8'h0c;

    // Unlock sequence values and progress codes
    localparam logic [31:0] UNLOCK_FIRST  = 32'h0000_0080;
    localparam logic [31:0] UNLOCK_SECOND = 32'h0000_0086;
    localparam logic [1:0]  UNLOCK_IDLE   = 2'd0;
    localparam logic [1:0]  UNLOCK_HALF   = 2'd1;
    localparam logic [1:0]  UNLOCK_OPEN   = 2'd2;

    // Reload register bits and flag readback
    localparam int          RELOAD_PING_BIT   = 8;
    localparam int          RELOAD_CLR_BIT_A  = 9;
    localparam int          RELOAD_CLR_BIT_B  = 12;
    localparam logic [15:0] FLAG_READ_VALUE   = 16'h1200;

    // Control and lock register bits
    localparam int CTRL_NO_REBOOT_BIT = 5;
    localparam int CTRL_FAST_BIT      = 2;
    localparam int LOCK_LOCK_BIT      = 0;
    localparam int LOCK_ENABLE_BIT    = 1;
    localparam int LOCK_FREE_BIT      = 2;

endpackage

@@ rtl/twdt_core.sv @@
// Watchdog state and single-pass update for one registered request.
// Depends on twdt_pkg.
module twdt_core
    import twdt_pkg::*;
#(
    parameter int PRELOAD_BITS = 20,
    parameter int SLOW_SHIFT   = 15,
    parameter int FAST_SHIFT   = 5
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  twdt_req_t item,
    output twdt_rsp_t result
);

    localparam int MAX_SHIFT = (SLOW_SHIFT > FAST_SHIFT) ? SLOW_SHIFT : FAST_SHIFT;
    localparam int CNT_W     = PRELOAD_BITS + MAX_SHIFT;
    localparam logic [PRELOAD_BITS-1:0] PRE_ONES = {PRELOAD_BITS{1'b1}};

    logic                    reboot_reg, reboot_next;
    logic                    fast_reg, fast_next;
    logic [1:0]              kind_reg, kind_next;
    logic                    free_reg, free_next;
    logic                    lock_reg, lock_next;
    logic                    on_reg, on_next;
    logic [PRELOAD_BITS-1:0] pre1_reg, pre1_next;
    logic [PRELOAD_BITS-1:0] pre2_reg, pre2_next;
    logic                    second_reg, second_next;
    logic [1:0]              progress_reg, progress_next;
    logic                    flag_reg, flag_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    running_reg, running_next;

    logic [31:0]             val;
    logic [CNT_W-1:0]        count_dec;
    logic                    hit_first;
    logic                    hit_second;

    // Scale a preload into a tick count
    function automatic logic [CNT_W-1:0] load_count(input logic [PRELOAD_BITS-1:0] pre,
                                                   input logic fast);
        logic [CNT_W-1:0] wide;
        begin
            wide = CNT_W'(pre);
            load_count = fast ? (wide << FAST_SHIFT) : (wide << SLOW_SHIFT);
        end
    endfunction

    // Mask write data to the access size
    always_comb
    begin
        priority if (item.access_bytes == LEN_BYTE)
            val = {24'd0, item.write_data[7:0]};
        else if (item.access_bytes == LEN_HALF)
            val = {16'd0, item.write_data[15:0]};
        else
            val = item.write_data;
    end

    assign count_dec  = (count_reg == '0) ? '0 : count_reg - CNT_W'(1);
    assign hit_first  = (item.address == ADDR_MEM_RELOAD) && (val == UNLOCK_FIRST);
    assign hit_second = (item.address == ADDR_MEM_RELOAD) && (val == UNLOCK_SECOND) &&
                        (progress_reg == UNLOCK_HALF);

    // Compute next state and the result for the current request
    always_comb
    begin
        reboot_next   = reboot_reg;
        fast_next     = fast_reg;
        kind_next     = kind_reg;
        free_next     = free_reg;
        lock_next     = lock_reg;
        on_next       = on_reg;
        pre1_next     = pre1_reg;
        pre2_next     = pre2_reg;
        second_next   = second_reg;
        progress_next = progress_reg;
        flag_next     = flag_reg;
        count_next    = count_reg;
        running_next  = running_reg;
        result        = '0;

        unique case (item.command)
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        if (!second_reg)
                        begin
                            // stage one expired: alert, start stage two
                            result.stage_one_alert = 1'b1;
                            result.alert_kind      = kind_reg;
                            if (on_reg)
                            begin
                                second_next  = 1'b1;
                                count_next   = load_count(pre2_reg, fast_reg);
                                running_next = 1'b1;
                            end
                        end
                        else
                        begin
                            running_next = 1'b0;
                            if (reboot_reg)
                            begin
                                // request reboot, drop all but the flag
                                flag_next             = 1'b1;
                                result.reboot_request = 1'b1;
                                reboot_next           = 1'b1;
                                fast_next             = 1'b0;
                                kind_next             = 2'd0;
                                free_next             = 1'b0;
                                lock_next             = 1'b0;
                                on_next               = 1'b0;
                                pre1_next             = PRE_ONES;
                                pre2_next             = PRE_ONES;
                                second_next           = 1'b0;
                                progress_next         = UNLOCK_IDLE;
                                count_next            = '0;
                            end
                            else if (free_reg && on_reg)
                            begin
                                second_next  = 1'b0;
                                count_next   = load_count(pre1_reg, fast_reg);
                                running_next = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_CFG_WR:
            begin
                if (item.address == ADDR_CFG_CTRL && item.access_bytes == LEN_HALF)
                begin
                    reboot_next = !val[CTRL_NO_REBOOT_BIT];
                    fast_next   = val[CTRL_FAST_BIT];
                    kind_next   = val[1:0];
                end
                else if (item.address == ADDR_CFG_LOCK && item.access_bytes == LEN_BYTE &&
                         !lock_reg)
                begin
                    lock_next = val[LOCK_LOCK_BIT];
                    free_next = val[LOCK_FREE_BIT];
                    on_next   = val[LOCK_ENABLE_BIT];
                    if (!on_reg && val[LOCK_ENABLE_BIT])
                    begin
                        second_next  = 1'b0;
                        count_next   = load_count(pre1_reg, fast_reg);
                        running_next = 1'b1;
                    end
                    else if (!val[LOCK_ENABLE_BIT])
                        running_next = 1'b0;
                end
            end
            CMD_CFG_RD:
            begin
                if (item.address == ADDR_CFG_CTRL && item.access_bytes == LEN_HALF)
                begin
                    result.read_data[CTRL_NO_REBOOT_BIT] = !reboot_reg;
                    result.read_data[CTRL_FAST_BIT]      = fast_reg;
                    result.read_data[1:0]                = kind_reg;
                end
                else if (item.address == ADDR_CFG_LOCK && item.access_bytes == LEN_BYTE)
                begin
                    result.read_data[LOCK_FREE_BIT]   = free_reg;
                    result.read_data[LOCK_ENABLE_BIT] = on_reg;
                    result.read_data[LOCK_LOCK_BIT]   = lock_reg;
                end
            end
            CMD_MEM_WR:
            begin
                if (item.access_bytes == LEN_BYTE || item.access_bytes == LEN_HALF ||
                    item.access_bytes == LEN_WORD)
                begin
                    // advance the unlock sequence, or act once it is open
                    if (hit_first)
                        progress_next = UNLOCK_HALF;
                    else if (hit_second)
                        progress_next = UNLOCK_OPEN;
                    else if (item.access_bytes != LEN_BYTE && progress_reg == UNLOCK_OPEN)
                    begin
                        progress_next = UNLOCK_IDLE;
                        if (item.access_bytes == LEN_HALF)
                        begin
                            if (item.address == ADDR_MEM_RELOAD)
                            begin
                                if (val[RELOAD_PING_BIT] && on_reg)
                                begin
                                    second_next  = 1'b0;
                                    count_next   = load_count(pre1_reg, fast_reg);
                                    running_next = 1'b1;
                                end
                                if (val[RELOAD_CLR_BIT_A] || val[RELOAD_CLR_BIT_B])
                                    flag_next = 1'b0;
                            end
                        end
                        else
                        begin
                            if (item.address == ADDR_MEM_PRE1)
                                pre1_next = val[PRELOAD_BITS-1:0];
                            else if (item.address == ADDR_MEM_PRE2)
                                pre2_next = val[PRELOAD_BITS-1:0];
                        end
                    end
                end
            end
            CMD_MEM_RD:
            begin
                if (item.address == ADDR_MEM_RELOAD && item.access_bytes == LEN_HALF)
                    result.read_data = flag_reg ? FLAG_READ_VALUE : 16'd0;
            end
            default:
            begin
                result.read_data = 16'd0;
            end
        endcase

        result.counting = running_next;
    end

    // Hold state, update on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reboot_reg   <= 1'b1;
            fast_reg     <= 1'b0;
            kind_reg     <= 2'd0;
            free_reg     <= 1'b0;
            lock_reg     <= 1'b0;
            on_reg       <= 1'b0;
            pre1_reg     <= PRE_ONES;
            pre2_reg     <= PRE_ONES;
            second_reg   <= 1'b0;
            progress_reg <= UNLOCK_IDLE;
            flag_reg     <= 1'b0;
            count_reg    <= '0;
            running_reg  <= 1'b0;
        end
        else if (go)
        begin
            reboot_reg   <= reboot_next;
            fast_reg     <= fast_next;
            kind_reg     <= kind_next;
            free_reg     <= free_next;
            lock_reg     <= lock_next;
            on_reg       <= on_next;
            pre1_reg     <= pre1_next;
            pre2_reg     <= pre2_next;
            second_reg   <= second_next;
            progress_reg <= progress_next;
            flag_reg     <= flag_next;
            count_reg    <= count_next;
            running_reg  <= running_next;
        end
    end

    // A running count always belongs to an enabled watchdog
    a_running_on: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> on_reg)
        else $error("count running while watchdog disabled");

    // Reboot leaves the flag set and the watchdog off
    a_reboot_state: assert property (@(posedge clk) disable iff (!rst_n)
        go && result.reboot_request |=> flag_reg && !on_reg && !running_reg)
        else $error("reboot did not reset state");

    // Stage one expiry moves to stage two
    a_alert_stage: assert property (@(posedge clk) disable iff (!rst_n)
        go && result.stage_one_alert |=> second_reg && running_reg)
        else $error("alert without stage two start");

    // Unlock progress never takes the unused code
    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg == UNLOCK_IDLE || progress_reg == UNLOCK_HALF ||
        progress_reg == UNLOCK_OPEN)
        else $error("bad unlock progress");

endmodule

@@ rtl/two_stage_watchdog_timer.sv @@
// Top level of the two-stage watchdog timer: request register, state core,
// result register. Depends on twdt_pkg and twdt_core.
//
//  channel   | signals                      | direction
//  ----------+------------------------------+----------
//  request   | req_valid, req_stall, req    | in
//  result    | rsp_valid, rsp_stall, rsp    | out
//
// One request per cycle sustained while rsp_stall is low; a result passes
// through the request register, then the result register, before it is
// offered on rsp.
// All state updates happen in one pass of logic between the two registers.
// rst_n resets all watchdog state asynchronously; the reboot flag is
// cleared only by rst_n or an unlocked reload write.
// req_stall rises only when a request is held and the result register is
// full and stalled.
module two_stage_watchdog_timer
    import twdt_pkg::*;
#(
    parameter int PRELOAD_BITS = 20,
    parameter int SLOW_SHIFT   = 15,
    parameter int FAST_SHIFT   = 5
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  twdt_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output twdt_rsp_t rsp
);

    logic      in_valid_reg, in_valid_next;
    twdt_req_t in_req_reg;
    logic      out_valid_reg, out_valid_next;
    twdt_rsp_t out_rsp_reg;
    twdt_rsp_t core_rsp;
    logic      advance;
    logic      accept;

    // Move the held request to the result side when there is room
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    twdt_core #(
        .PRELOAD_BITS (PRELOAD_BITS),
        .SLOW_SHIFT   (SLOW_SHIFT),
        .FAST_SHIFT   (FAST_SHIFT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (in_req_reg),
        .result (core_rsp)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture request and result payloads
    always_ff @(posedge clk)
    begin
        if (accept)
            in_req_reg <= req;
        if (advance)
            out_rsp_reg <= core_rsp;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule
